// ----- rtl/long_fir_convolution_defines.svh -----
// assertion macros shared by the long fir convolution rtl
`ifndef LONG_FIR_CONVOLUTION_DEFINES_SVH
`define LONG_FIR_CONVOLUTION_DEFINES_SVH

// same-cycle implication, sampled on clk and quiet during reset
`define LFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and quiet during reset
`define LFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lfc_pkg.sv -----
// shared types and constants of the long fir convolution block
package lfc_pkg;

    // default depth of the tap store and the history ring
    localparam int DEFAULT_MAX_TAPS = 1024;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 10;
    localparam int CNT_REG_W   = 11;

    // configuration port
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int RIDX_W  = ADDR_W - 2;
    localparam logic [RIDX_W-1:0] REG_TAP_COUNT = RIDX_W'(0);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // one queued command
    typedef struct packed {
        kind_t                         kind;
        logic [IDX_W-1:0]              tap_index;
        logic signed [SAMPLE_BITS-1:0] value;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic can_push;
        logic has_data;
    } q_status_t;

    // back end status seen by the front
    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// ----- rtl/lfc_stream_if.sv -----
// item and result channel interfaces
interface lfc_item_if;
    import lfc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [KIND_W-1:0]             kind;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] value;

    modport source (output valid, output kind, output tap_index, output value, input ready);
    modport sink (input valid, input kind, input tap_index, input value, output ready);
endinterface

interface lfc_result_if;
    import lfc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

// ----- rtl/lfc_front.sv -----
// front end: takes items, drops unused kinds and queues commands
module lfc_front (
    lfc_item_if.sink             item,
    input  lfc_pkg::q_status_t   q_status,
    input  lfc_pkg::back_status_t back_status,
    output logic                 push,
    output lfc_pkg::cmd_t        push_data
);
    import lfc_pkg::*;

    logic take;
    logic known;

    // hold off while the stores are being cleared after reset
    assign item.ready = q_status.can_push && !back_status.init_busy;
    assign take       = item.valid && item.ready;

    // classify the item kind
    always_comb
    begin
        unique case (kind_t'(item.kind))
            KIND_SAMPLE, KIND_LOAD, KIND_CLEAR: known = 1'b1;
            default:                            known = 1'b0;
        endcase
    end

    // unused kind is taken and dropped
    assign push                = take && known;
    assign push_data.kind      = kind_t'(item.kind);
    assign push_data.tap_index = item.tap_index;
    assign push_data.value     = item.value;

endmodule

// ----- rtl/lfc_queue.sv -----
// short command queue between front and back
module lfc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lfc_pkg::cmd_t      push_data,
    input  logic               pop,
    output lfc_pkg::cmd_t      head,
    output lfc_pkg::q_status_t status
);
    import lfc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head            = entry_reg[rd_ptr_reg];
    assign status.can_push = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign status.has_data = count_reg != '0;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/lfc_back.sv -----
// back end: tap and history stores, multiply-accumulate and output register
`include "long_fir_convolution_defines.svh"

module lfc_back #(
    parameter int MAX_TAPS = lfc_pkg::DEFAULT_MAX_TAPS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [lfc_pkg::CNT_REG_W-1:0]   tap_count,
    input  lfc_pkg::cmd_t                   head,
    input  lfc_pkg::q_status_t              q_status,
    output logic                            pop,
    output lfc_pkg::back_status_t           status,
    lfc_result_if.source                    result
);
    import lfc_pkg::*;

    localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + CNT_W + 1;
    localparam logic [PTR_W-1:0]        LAST_ADDR  = PTR_W'(MAX_TAPS - 1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [ACC_W-1:0] SAT_MAX    =
        (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -(ACC_W'(1) << (SAMPLE_BITS - 1));

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_MAC   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                          sweep_taps_reg, sweep_taps_next;
    logic [PTR_W-1:0]              addr_reg, addr_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic [PTR_W-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]              k_reg, k_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic                          rd_vld_reg, prod_vld_reg;
    logic signed [SAMPLE_BITS-1:0] tap_q, hist_q;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

    logic                          tap_we, hist_we;
    logic [PTR_W-1:0]              tap_waddr, hist_waddr;
    logic signed [SAMPLE_BITS-1:0] tap_wdata, hist_wdata;
    logic                          issue;
    logic [CNT_W-1:0]              n_eff;
    logic                          out_free;
    logic signed [ACC_W-1:0]       rounded, shifted;
    logic signed [SAMPLE_BITS-1:0] sat_val;

    assign status.init_busy = (state_reg == ST_SWEEP) && sweep_taps_reg;
    assign result.valid      = out_valid_reg;
    assign result.out_sample = out_sample_reg;
    assign out_free          = !out_valid_reg || result.ready;

    // taps in use, clamped to the store depth
    assign n_eff = (32'(tap_count) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);
    assign issue = (state_reg == ST_MAC) && (k_reg != n_eff);

    // round half up, then saturate
    assign rounded = acc_reg + ROUND_HALF;
    assign shifted = rounded >>> (SAMPLE_BITS - 1);
    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            sat_val = SAMPLE_BITS'(SAT_MAX);
        end
        else if (shifted < SAT_MIN)
        begin
            sat_val = SAMPLE_BITS'(SAT_MIN);
        end
        else
        begin
            sat_val = SAMPLE_BITS'(shifted);
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sweep_taps_next = sweep_taps_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        wp_next         = wp_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        pop             = 1'b0;
        tap_we          = 1'b0;
        tap_waddr       = addr_reg;
        tap_wdata       = '0;
        hist_we         = 1'b0;
        hist_waddr      = addr_reg;
        hist_wdata      = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                hist_we = 1'b1;
                tap_we  = sweep_taps_reg;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next       = '0;
                    sweep_taps_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (q_status.has_data)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        KIND_SAMPLE:
                        begin
                            hist_we    = 1'b1;
                            hist_waddr = wp_reg;
                            hist_wdata = head.value;
                            pos_next   = wp_reg;
                            wp_next    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                            k_next     = '0;
                            acc_next   = '0;
                            state_next = ST_MAC;
                        end
                        KIND_LOAD:
                        begin
                            idx_next   = head.tap_index;
                            val_next   = head.value;
                            state_next = ST_LOAD;
                        end
                        KIND_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                // index reduced one subtraction a cycle
                if (32'(idx_reg) >= 32'(MAX_TAPS))
                begin
                    idx_next = idx_reg - IDX_W'(MAX_TAPS);
                end
                else
                begin
                    tap_we     = 1'b1;
                    tap_waddr  = PTR_W'(idx_reg);
                    tap_wdata  = val_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    k_next   = k_reg + 1'b1;
                    pos_next = (pos_reg == '0) ? LAST_ADDR : pos_reg - 1'b1;
                end
                else if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_taps_reg <= 1'b1;
            addr_reg       <= '0;
            wp_reg         <= '0;
            k_reg          <= '0;
            rd_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_taps_reg <= sweep_taps_next;
            addr_reg       <= addr_next;
            wp_reg         <= wp_next;
            k_reg          <= k_next;
            rd_vld_reg     <= issue;
            prod_vld_reg   <= rd_vld_reg;
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        acc_reg  <= acc_next;
        prod_reg <= PROD_W'(tap_q) * PROD_W'(hist_q);
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_sample_reg <= sat_val;
        end
    end

    // tap store
    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        if (issue)
        begin
            tap_q <= tap_mem[k_reg[PTR_W-1:0]];
        end
    end

    // history ring
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (issue)
        begin
            hist_q <= hist_mem[pos_reg];
        end
    end

    `LFC_ASSERT_NOW(a_read_only_in_mac, rd_vld_reg, $past(state_reg == ST_MAC), "read outside mac")
    `LFC_ASSERT_NOW(a_prod_follows_read, prod_vld_reg, $past(rd_vld_reg), "stray product")
    `LFC_ASSERT_NOW(a_count_bound, state_reg == ST_MAC, k_reg <= n_eff, "tap counter overrun")
    `LFC_ASSERT_NOW(a_out_from_emit, $rose(out_valid_reg), $past(state_reg == ST_EMIT), "stray result")

endmodule

// ----- rtl/long_fir_convolution.sv -----
// top level of the long fir convolution block
//
//   channel   dir  handshake          payload
//   item      in   valid / ready      kind, tap_index, value
//   result    out  valid / ready      out_sample
//   apb       in   psel / penable     paddr, pwdata, prdata (tap_count at 0)
//
// a sample takes one multiply-accumulate per tap in use, min(tap_count, MAX_TAPS), through
// the single multiplier, plus read and product stages
// a tap load first steps MAX_TAPS off an oversized index until it fits, then writes the tap
// a history clear sweeps the whole ring, one ring entry per cycle
// after reset both stores are cleared, every entry, with item ready low
// a two-entry command queue lets items be taken while the back end works
module long_fir_convolution #(
    parameter int MAX_TAPS = lfc_pkg::DEFAULT_MAX_TAPS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lfc_item_if.sink                     item,
    lfc_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lfc_pkg::DATA_W-1:0]   pwdata,
    output logic [lfc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lfc_pkg::*;

    logic [CNT_REG_W-1:0] tap_count_reg;
    logic [RIDX_W-1:0]    reg_idx;
    logic                 push;
    logic                 pop;
    cmd_t                 push_data;
    cmd_t                 head;
    q_status_t            q_status;
    back_status_t         back_status;

    // configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (reg_idx == REG_TAP_COUNT))
        begin
            tap_count_reg <= pwdata[CNT_REG_W-1:0];
        end
    end

    // register read back
    always_comb
    begin
        priority if (reg_idx == REG_TAP_COUNT)
        begin
            prdata = DATA_W'(tap_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    lfc_front u_front (
        .item        (item),
        .q_status    (q_status),
        .back_status (back_status),
        .push        (push),
        .push_data   (push_data)
    );

    lfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    lfc_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_count (tap_count_reg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .status    (back_status),
        .result    (result)
    );

endmodule
